/* rtl/core/kle_pkg.sv */
// Shared types and constants for the keystroke line editor.
// No dependencies; imported by every module of the block except kle_ram.
`default_nettype none

package kle_pkg;

	// Field widths fixed by the interface
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int POS_W  = 11;
	localparam int LEN_W  = 12;

	// Opcodes
	localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Special keystrokes
	localparam logic [CHAR_W-1:0] KEY_DELETE = 8'h2D;  // '-'
	localparam logic [CHAR_W-1:0] KEY_LEFT   = 8'h3C;  // '<'
	localparam logic [CHAR_W-1:0] KEY_RIGHT  = 8'h3E;  // '>'

	// Classified command, as handed from front to back
	typedef enum logic [2:0] {
		CMD_INS,
		CMD_DEL,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_READ,
		CMD_CLEAR,
		CMD_NOP
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t              cmd;
		logic [CHAR_W-1:0]   data;
		logic [POS_W-1:0]    pos;
	} q_entry_t;

endpackage

`default_nettype wire

/* rtl/core/kle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/kle_front.sv */
// Front end: accepts input words, decodes them into commands, and queues them.
// Depends on kle_pkg.
`default_nettype none

module kle_front import kle_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [CHAR_W-1:0] key_byte,
	input  wire logic [POS_W-1:0]  read_position,
	output logic                   q_valid,
	output q_entry_t               q_entry,
	input  wire logic              q_pop
);

	localparam int QD   = 2;
	localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
	localparam int CNTW = $clog2(QD + 1);

	q_entry_t         entry_q [QD];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	q_entry_t         cls;
	logic             push;
	logic             pop;

	// decode opcode and keystroke
	always_comb begin
		cls.data = key_byte;
		cls.pos  = read_position;
		case (opcode)
			OP_KEY: begin
				case (key_byte)
					KEY_DELETE: cls.cmd = CMD_DEL;
					KEY_LEFT:   cls.cmd = CMD_LEFT;
					KEY_RIGHT:  cls.cmd = CMD_RIGHT;
					default:    cls.cmd = CMD_INS;
				endcase
			end
			OP_READ:  cls.cmd = CMD_READ;
			OP_CLEAR: cls.cmd = CMD_CLEAR;
			default:  cls.cmd = CMD_NOP;
		endcase
	end

	// an unused opcode is accepted and dropped here
	assign in_ready = (cnt_q != CNTW'(QD));
	assign push     = in_valid && in_ready && (cls.cmd != CMD_NOP);
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/kle_back.sv */
// Back end: executes queued commands on the two stacks and drives read results.
// Depends on kle_pkg and kle_ram.
`default_nettype none

module kle_back import kle_pkg::*; #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire q_entry_t          q_entry,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CHAR_W-1:0]      text_char,
	output logic                   in_range,
	output logic [LEN_W-1:0]       line_length
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int TW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WAIT = 2'b10
	} state_t;

	state_t            state_q, state_d;
	cmd_e_t            op_q, op_d;
	logic              hit_q, hit_d;
	logic              from_left_q, from_left_d;
	logic [CW-1:0]     lc_q, lc_d;
	logic [CW-1:0]     rc_q, rc_d;
	logic              out_valid_q;
	logic [CHAR_W-1:0] text_char_q;
	logic              in_range_q;
	logic [LEN_W-1:0]  line_length_q;
	logic              out_load;

	logic [CW-1:0]     lc_dec, rc_dec;
	logic [TW-1:0]     lc_x, rc_x, pos_x, total_x, r_idx;
	logic              left_full, right_full;

	logic              l_wr_en, l_rd_en, r_wr_en, r_rd_en;
	logic [AW-1:0]     l_wr_addr, l_rd_addr, r_wr_addr, r_rd_addr;
	logic [CHAR_W-1:0] l_wr_data, r_wr_data, l_rd_data, r_rd_data;

	// stack pointers and read index math
	assign lc_dec     = lc_q - CW'(1);
	assign rc_dec     = rc_q - CW'(1);
	assign lc_x       = TW'(lc_q);
	assign rc_x       = TW'(rc_q);
	assign pos_x      = TW'(q_entry.pos);
	assign total_x    = lc_x + rc_x;
	assign r_idx      = total_x - TW'(1) - pos_x;
	assign left_full  = (lc_q == CW'(STACK_DEPTH));
	assign right_full = (rc_q == CW'(STACK_DEPTH));

	// command sequencer
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		hit_d       = hit_q;
		from_left_d = from_left_q;
		lc_d        = lc_q;
		rc_d        = rc_q;
		q_pop       = 1'b0;
		out_load    = 1'b0;
		l_wr_en     = 1'b0;
		l_wr_addr   = lc_q[AW-1:0];
		l_wr_data   = q_entry.data;
		l_rd_en     = 1'b0;
		l_rd_addr   = lc_dec[AW-1:0];
		r_wr_en     = 1'b0;
		r_wr_addr   = rc_q[AW-1:0];
		r_wr_data   = l_rd_data;
		r_rd_en     = 1'b0;
		r_rd_addr   = rc_dec[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					op_d  = q_entry.cmd;
					case (q_entry.cmd)
						CMD_INS: begin
							if (!left_full) begin
								l_wr_en = 1'b1;
								lc_d    = lc_q + CW'(1);
							end
						end
						CMD_DEL: begin
							if (lc_q != '0) begin
								lc_d = lc_dec;
							end
						end
						CMD_LEFT: begin
							if (lc_q != '0) begin
								l_rd_en = 1'b1;
								state_d = ST_WAIT;
							end
						end
						CMD_RIGHT: begin
							if (rc_q != '0) begin
								r_rd_en = 1'b1;
								state_d = ST_WAIT;
							end
						end
						CMD_READ: begin
							// fetch both candidates, pick one when data returns
							hit_d       = (pos_x < total_x);
							from_left_d = (pos_x < lc_x);
							l_rd_en     = 1'b1;
							l_rd_addr   = pos_x[AW-1:0];
							r_rd_en     = 1'b1;
							r_rd_addr   = r_idx[AW-1:0];
							state_d     = ST_WAIT;
						end
						CMD_CLEAR: begin
							lc_d = '0;
							rc_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WAIT: begin
				case (op_q)
					CMD_LEFT: begin
						// pop left top, push onto right unless full
						lc_d    = lc_dec;
						state_d = ST_IDLE;
						if (!right_full) begin
							r_wr_en = 1'b1;
							rc_d    = rc_q + CW'(1);
						end
					end
					CMD_RIGHT: begin
						rc_d      = rc_dec;
						state_d   = ST_IDLE;
						l_wr_data = r_rd_data;
						if (!left_full) begin
							l_wr_en = 1'b1;
							lc_d    = lc_q + CW'(1);
						end
					end
					CMD_READ: begin
						// hold here while the output word is stalled
						if (!out_valid_q || out_ready) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lc_q        <= '0;
			rc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lc_q    <= lc_d;
			rc_q    <= rc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command context and output word
	always_ff @(posedge clk) begin
		op_q        <= op_d;
		hit_q       <= hit_d;
		from_left_q <= from_left_d;
		if (out_load) begin
			text_char_q   <= !hit_q ? '0 : (from_left_q ? l_rd_data : r_rd_data);
			in_range_q    <= hit_q;
			line_length_q <= LEN_W'(lc_x + rc_x);
		end
	end

	assign out_valid   = out_valid_q;
	assign text_char   = text_char_q;
	assign in_range    = in_range_q;
	assign line_length = line_length_q;

	// text before the cursor
	kle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (STACK_DEPTH)
	) u_left_ram (
		.clk     (clk),
		.wr_en   (l_wr_en),
		.wr_addr (l_wr_addr),
		.wr_data (l_wr_data),
		.rd_en   (l_rd_en),
		.rd_addr (l_rd_addr),
		.rd_data (l_rd_data)
	);

	// text after the cursor, top nearest the cursor
	kle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (STACK_DEPTH)
	) u_right_ram (
		.clk     (clk),
		.wr_en   (r_wr_en),
		.wr_addr (r_wr_addr),
		.wr_data (r_wr_data),
		.rd_en   (r_rd_en),
		.rd_addr (r_rd_addr),
		.rd_data (r_rd_data)
	);

endmodule

`default_nettype wire

/* rtl/core/keystroke_line_editor.sv */
// Keystroke line editor top level: two-stack gap buffer around a cursor.
// Depends on kle_pkg, kle_front, kle_back (and kle_ram through kle_back).
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per opcode: a keystroke
//   (delete, cursor left, cursor right, or insert of key_byte), a read of the
//   character at read_position, or a clear of the line. Opcode 3 is taken
//   and ignored.
//   Output channel (out_valid/out_ready) returns one word for each read:
//   text_char (zero when out of range), in_range and line_length.
//   The front decodes words into a two-entry command queue; the back runs
//   one command at a time against two stack RAMs of STACK_DEPTH bytes.
//   Insert, delete and clear finish in ST_IDLE. A cursor move or a read
//   also passes ST_WAIT: first the registered RAM read, then a write to the
//   other stack or a load of the output register. The queue takes new words
//   while the back is busy; a read result passes through the queue, the
//   RAM read register and the output register.
//   Reset empties both stacks at once (counts only, RAM contents are kept)
//   and empties the queue. When the receiver stalls, the result stays in the
//   output register, the back holds the next read, and the queue fills and
//   then drops in_ready; keystrokes still run while a result waits.
`default_nettype none

module keystroke_line_editor import kle_pkg::*; #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [CHAR_W-1:0] key_byte,
	input  wire logic [POS_W-1:0]  read_position,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CHAR_W-1:0]      text_char,
	output logic                   in_range,
	output logic [LEN_W-1:0]       line_length
);

	logic     q_valid;
	logic     q_pop;
	q_entry_t q_entry;

	kle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.key_byte      (key_byte),
		.read_position (read_position),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop)
	);

	kle_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.text_char   (text_char),
		.in_range    (in_range),
		.line_length (line_length)
	);

endmodule

`default_nettype wire

/* rtl/core/kle_chk.sv */
// Port-level checker for the keystroke line editor, bound to the top level.
// Depends on kle_pkg and keystroke_line_editor.
`default_nettype none

module kle_chk import kle_pkg::*; #(
	parameter int STACK_DEPTH = 1024
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [CHAR_W-1:0] text_char,
	input wire logic              in_range,
	input wire logic [LEN_W-1:0]  line_length
);

	localparam longint LEN_MAX = 2 * longint'(STACK_DEPTH);
	localparam bit     LEN_WRAPS = (LEN_MAX > 4095);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(text_char)
			&& $stable(in_range) && $stable(line_length))
		else $error("result word changed while stalled");

	// out-of-range reads return a zero character
	a_zero_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> text_char == '0)
		else $error("out-of-range read returned a nonzero character");

	// an in-range read implies a nonempty line
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range && !LEN_WRAPS |-> line_length != '0)
		else $error("in-range read on an empty line");

	// line never exceeds both stacks full
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> LEN_WRAPS || (longint'(line_length) <= LEN_MAX))
		else $error("line length beyond capacity");

	// no result word during reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind keystroke_line_editor kle_chk #(
	.STACK_DEPTH (STACK_DEPTH)
) u_kle_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.text_char   (text_char),
	.in_range    (in_range),
	.line_length (line_length)
);

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for keystroke_line_editor (two-stack line editor).
// Depends on kle_pkg and the keystroke_line_editor RTL; keeps its own line model.
// Named tests run in turn; one task sends words, one process checks read replies.
`default_nettype none

module testbench;
	import kle_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RUN_LIMIT_CYCLES = 500000;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              hit;
		logic [LEN_W-1:0]  len;
	} read_reply_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [OP_W-1:0] opcode;
	logic [CHAR_W-1:0] key_byte;
	logic [POS_W-1:0] read_position;
	logic out_valid;
	logic out_ready;
	logic [CHAR_W-1:0] text_char;
	logic in_range;
	logic [LEN_W-1:0] line_length;

	// Line model: text left of the cursor and right of it, top nearest the cursor
	logic [CHAR_W-1:0] left_text [LINE_DEPTH];
	logic [CHAR_W-1:0] right_text [LINE_DEPTH];
	int unsigned left_len;
	int unsigned right_len;

	read_reply_t expected_reads[$];
	int mismatch_count;

	// Idle knobs: percent of words/replies drawn with no wait, and a long hold-off
	int feed_quiet_pct;
	int drain_quiet_pct;
	int drain_hold_cycles;

	keystroke_line_editor #(
		.STACK_DEPTH(LINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.key_byte(key_byte),
		.read_position(read_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_char(text_char),
		.in_range(in_range),
		.line_length(line_length)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_CYCLES * 8);
		$display("tb: failure");
		$finish;
	end

	function automatic int draw_wait(input int quiet_pct);
		if ($urandom_range(0, 99) < quiet_pct)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic int pick_quiet_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 60;
			default: return 100;
		endcase
	endfunction

	// A byte that inserts rather than edits
	function automatic logic [CHAR_W-1:0] text_byte();
		logic [CHAR_W-1:0] b;
		do
			b = CHAR_W'($urandom_range(0, 255));
		while (b == KEY_DELETE || b == KEY_LEFT || b == KEY_RIGHT);
		return b;
	endfunction

	// Apply one accepted word to the line model; reads queue their reply
	function automatic void apply_to_line(input logic [OP_W-1:0] op,
			input logic [CHAR_W-1:0] key, input logic [POS_W-1:0] pos);
		read_reply_t reply;
		logic [CHAR_W-1:0] moved;
		int unsigned total;
		case (op)
			OP_KEY: begin
				if (key == KEY_DELETE) begin
					if (left_len > 0)
						left_len--;
				end else if (key == KEY_LEFT) begin
					if (left_len > 0) begin
						left_len--;
						moved = left_text[left_len];
						// a push into a full stack loses the character
						if (right_len < LINE_DEPTH) begin
							right_text[right_len] = moved;
							right_len++;
						end
					end
				end else if (key == KEY_RIGHT) begin
					if (right_len > 0) begin
						right_len--;
						moved = right_text[right_len];
						if (left_len < LINE_DEPTH) begin
							left_text[left_len] = moved;
							left_len++;
						end
					end
				end else if (left_len < LINE_DEPTH) begin
					left_text[left_len] = key;
					left_len++;
				end
			end
			OP_CLEAR: begin
				left_len = 0;
				right_len = 0;
			end
			OP_READ: begin
				total = left_len + right_len;
				reply.ch = '0;
				reply.hit = 1'b0;
				reply.len = LEN_W'(total);
				if (pos < left_len) begin
					reply.ch = left_text[pos];
					reply.hit = 1'b1;
				end else if (pos < total) begin
					reply.ch = right_text[right_len - 1 - (pos - left_len)];
					reply.hit = 1'b1;
				end
				expected_reads.push_back(reply);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH: %s", msg);
	endtask

	// Send one word; entered and left at a falling edge
	task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] key,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = draw_wait(feed_quiet_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key_byte <= key;
		read_position <= pos;
		do
			@(posedge clk);
		while (!in_ready);
		apply_to_line(op, key, pos);
		@(negedge clk);
	endtask

	task automatic send_key(input logic [CHAR_W-1:0] key);
		send_word(OP_KEY, key, POS_W'($urandom_range(0, 2047)));
	endtask

	task automatic send_read(input logic [POS_W-1:0] pos);
		send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), pos);
	endtask

	// Reply drain: random stall per reply, plus an optional long hold-off
	initial begin : reply_drain
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(drain_quiet_pct);
			if (stall > 0 || drain_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				while (drain_hold_cycles > 0) begin
					@(negedge clk);
					drain_hold_cycles--;
				end
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			@(negedge clk);
		end
	end

	// Compare each reply with the oldest expected one
	initial begin : reply_checker
		read_reply_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
				if (expected_reads.size() == 0) begin
					report_mismatch($sformatf("unexpected reply char %0h in_range %0b len %0d",
						text_char, in_range, line_length));
				end else begin
					want = expected_reads.pop_front();
					if (text_char !== want.ch || in_range !== want.hit ||
							line_length !== want.len)
						report_mismatch($sformatf(
							"read reply got char %0h in_range %0b len %0d, want %0h %0b %0d",
							text_char, in_range, line_length, want.ch, want.hit, want.len));
				end
			end
		end
	end

	// Edits and reads on an empty line, and the ignored opcode
	task automatic test_empty_line();
		send_read(11'd0);
		send_read(11'd2047);
		send_key(KEY_DELETE);
		send_key(KEY_LEFT);
		send_key(KEY_RIGHT);
		send_word(OP_UNUSED, KEY_LEFT, 11'h7FF);
		send_read(11'd0);
	endtask

	// Inserts of extreme bytes, moves, delete, reads in and out of range, clear
	task automatic test_basic_edits();
		int i;
		send_key(8'h00);
		send_key(8'hFF);
		send_key(8'h61);
		send_key(KEY_LEFT);
		send_key(KEY_LEFT);
		send_key(8'h7F);
		for (i = 0; i < 5; i++)
			send_read(POS_W'(i));
		send_key(KEY_DELETE);
		send_key(KEY_RIGHT);
		send_key(KEY_RIGHT);
		send_key(KEY_RIGHT);
		send_read(11'd2);
		send_word(OP_CLEAR, 8'hFF, 11'h7FF);
		send_read(11'd0);
	endtask

	// Fill the left stack past its depth, then move a character into the full left stack
	task automatic test_full_stacks();
		int i;
		feed_quiet_pct = 90;
		drain_quiet_pct = 50;
		send_word(OP_CLEAR, 8'h00, 11'd0);
		for (i = 0; i < LINE_DEPTH + 2; i++) begin
			send_key(text_byte());
			if (i % 64 == 63)
				send_read(POS_W'($urandom_range(0, 2047)));
		end
		send_read(POS_W'(LINE_DEPTH - 1));
		send_read(POS_W'(LINE_DEPTH));
		// open room on the left, then refill it; the last insert is dropped
		send_key(KEY_LEFT);
		send_key(KEY_LEFT);
		for (i = 0; i < 3; i++)
			send_key(text_byte());
		// this move drops a character: the left stack is full
		send_key(KEY_RIGHT);
		for (i = 0; i < 4; i++)
			send_read(POS_W'(LINE_DEPTH - 2 + i));
		send_key(KEY_RIGHT);
		send_key(KEY_RIGHT);
		send_read(POS_W'(LINE_DEPTH));
		// walk the cursor back across part of the line
		for (i = 0; i < 40; i++) begin
			send_key(KEY_LEFT);
			if (i % 8 == 0)
				send_read(POS_W'($urandom_range(0, LINE_DEPTH - 1)));
		end
		send_key(KEY_DELETE);
		send_key(KEY_DELETE);
		send_read(11'd0);
		send_read(POS_W'(LINE_DEPTH - 1));
		send_read(POS_W'($urandom_range(0, 2047)));
		send_word(OP_CLEAR, 8'h00, 11'd0);
		send_read(11'd0);
	endtask

	// Hold replies off long enough that the block fills and drops in_ready
	task automatic test_reply_backpressure();
		int i;
		feed_quiet_pct = 100;
		drain_quiet_pct = 100;
		for (i = 0; i < 6; i++)
			send_key(text_byte());
		drain_hold_cycles = 300;
		for (i = 0; i < 12; i++) begin
			send_read(POS_W'($urandom_range(0, 7)));
			if (i % 3 == 1)
				send_key(i % 2 ? KEY_LEFT : text_byte());
		end
	endtask

	// Random editing sessions with reads, occasional clears and unused opcodes
	task automatic test_random_edits(input int count);
		int i;
		int r;
		int len;
		logic [CHAR_W-1:0] k;
		logic [POS_W-1:0] p;
		for (i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				feed_quiet_pct = pick_quiet_pct();
				drain_quiet_pct = pick_quiet_pct();
			end
			r = $urandom_range(0, 99);
			len = left_len + right_len;
			if (r < 68) begin
				case ($urandom_range(0, 9))
					0, 1: k = KEY_DELETE;
					2, 3: k = KEY_LEFT;
					4, 5: k = KEY_RIGHT;
					default: k = CHAR_W'($urandom_range(0, 255));
				endcase
				send_key(k);
			end else if (r < 94) begin
				if (len > 2047)
					p = POS_W'($urandom_range(0, 2047));
				else
					p = POS_W'($urandom_range(0, len));
				send_read(p);
			end else if (r < 96) begin
				send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, 2047)));
			end else if (r < 98) begin
				send_word(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, 2047)));
			end else begin
				send_read(POS_W'($urandom_range(0, 2047)));
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < LINE_DEPTH; i++) begin
			left_text[i] = '0;
			right_text[i] = '0;
		end
		left_len = 0;
		right_len = 0;
		mismatch_count = 0;
		feed_quiet_pct = 50;
		drain_quiet_pct = 50;
		drain_hold_cycles = 0;
		in_valid = 1'b0;
		opcode = OP_KEY;
		key_byte = '0;
		read_position = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_line();
		test_basic_edits();
		test_reply_backpressure();
		test_full_stacks();
		test_random_edits(700);

		in_valid <= 1'b0;
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

/* keystroke_line_editor.f */
rtl/core/kle_pkg.sv
rtl/core/kle_ram.sv
rtl/core/kle_front.sv
rtl/core/kle_back.sv
rtl/core/keystroke_line_editor.sv
rtl/core/kle_chk.sv
test/testbench.sv
